/* src/rbe_pkg.sv */
`timescale 1ns / 1ps

package rbe_pkg;

  localparam int NumAxes  = 3;
  localparam int NumFaces = 6;
  localparam int Kept     = 2;
  localparam int FaceIdxW = 3;
  localparam int RegIdxW  = 3;

  localparam int AxX = 0;
  localparam int AxY = 1;
  localparam int AxZ = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_e;

  // face pairs are visited z, x, y
  function automatic int face_axis(input int g);
    int a;
    a = AxY;
    unique case (g)
      0: a = AxZ;
      1: a = AxX;
      default: a = AxY;
    endcase
    return a;
  endfunction

  // the two axes spanning the face plane
  function automatic int other_axis(input int g, input int j);
    int b;
    b = AxX;
    unique case (g)
      0: b = (j != 0) ? AxY : AxX;
      1: b = (j != 0) ? AxZ : AxY;
      default: b = (j != 0) ? AxZ : AxX;
    endcase
    return b;
  endfunction

endpackage

/* src/rbe_div.sv */
`timescale 1ns / 1ps

module rbe_div #(
  parameter int CW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [2*CW-1:0]      dividend_i,
  input  logic [CW-1:0]        divisor_i,
  input  logic                 neg_i,
  output logic signed [CW+1:0] quot_o,
  output logic                 ovf_o,
  output logic                 neg_o
);

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] lo;
    logic [CW-1:0] quo;
    logic [CW-1:0] dv;
    logic          ovf;
    logic          neg;
  } stg_t;

  stg_t st_q [CW+1];
  stg_t st_d [CW+1];

  logic                 rnd;
  logic [CW:0]          qm;
  logic signed [CW+1:0] qs_d;
  logic signed [CW+1:0] qs_q;
  logic                 ovf_q;
  logic                 neg_q;

  // one quotient bit per stage, restoring
  always_comb begin
    logic [CW:0] t;
    logic [CW:0] df;
    logic        ge;
    st_d[0].rem = dividend_i[2*CW-1:CW];
    st_d[0].lo  = dividend_i[CW-1:0];
    st_d[0].quo = '0;
    st_d[0].dv  = divisor_i;
    st_d[0].ovf = (dividend_i[2*CW-1:CW] >= divisor_i);
    st_d[0].neg = neg_i;
    for (int k = 1; k <= CW; k++) begin
      t  = {st_q[k-1].rem, st_q[k-1].lo[CW-1]};
      df = t - {1'b0, st_q[k-1].dv};
      ge = (t >= {1'b0, st_q[k-1].dv});
      st_d[k].rem = ge ? df[CW-1:0] : t[CW-1:0];
      st_d[k].lo  = {st_q[k-1].lo[CW-2:0], 1'b0};
      st_d[k].quo = {st_q[k-1].quo[CW-2:0], ge};
      st_d[k].dv  = st_q[k-1].dv;
      st_d[k].ovf = st_q[k-1].ovf;
      st_d[k].neg = st_q[k-1].neg;
    end
  end

  // round half away from zero, then apply sign
  always_comb begin
    rnd  = ({st_q[CW].rem, 1'b0} >= {1'b0, st_q[CW].dv});
    qm   = {1'b0, st_q[CW].quo} + {{CW{1'b0}}, rnd};
    qs_d = st_q[CW].neg ? -$signed((CW+2)'(qm)) : $signed((CW+2)'(qm));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      qs_q  <= qs_d;
      ovf_q <= st_q[CW].ovf;
      neg_q <= st_q[CW].neg;
    end
  end

  assign quot_o = qs_q;
  assign ovf_o  = ovf_q;
  assign neg_o  = neg_q;

endmodule

/* src/ray_box_entry_exit_points_top.sv */
`timescale 1ns / 1ps

// ray / box crossing pipeline: one ray (origin, direction) per transaction, one result per
// ray, a new ray accepted every cycle unless m_axis_tready holds the pipeline; a
// bit-per-stage quotient pipeline places the crossing points; the line is tested against
// the box faces in the order zmin, zmax, xmin, xmax, ymin, ymax, the first two faces crossed
// within the inclusive bounds are kept and given nearest first; with fewer than two, hit is
// 0 and all coordinates are 0; the user must write the box registers only while no ray is
// in flight, and the block itself does not enforce this
module ray_box_entry_exit_points_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [rbe_pkg::RegIdxW-1:0]              cfg_idx_i,
  input  logic [COORD_BITS-1:0]                    cfg_data_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // hit, near_x, near_y, near_z, far_x, far_y, far_z, zero fill
  output logic [((1+6*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata
);

  import rbe_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int W    = CW + 1;      // bound minus origin
  localparam int PW   = 2 * CW + 1;  // signed cross products
  localparam int MW   = 2 * CW;      // product magnitudes
  localparam int OutW = ((1 + 6 * CW + 7) / 8) * 8;
  localparam int Lat  = CW + 2;      // quotient pipeline depth

  typedef logic signed [CW-1:0] crd_t;

  localparam crd_t MaxV   = {1'b0, {(CW-1){1'b1}}};
  localparam crd_t MinV   = {1'b1, {(CW-1){1'b0}}};
  localparam crd_t OneV   = CW'(64'd1 << FRAC_BITS);

  // saturating add of origin and signed quotient
  function automatic crd_t sat_add(input crd_t o, input logic signed [CW+1:0] q,
                                   input logic ovf, input logic ng);
    logic signed [CW+2:0] s;
    crd_t r;
    s = (CW+3)'(o) + (CW+3)'(q);
    if (ovf) r = ng ? MinV : MaxV;
    else if (s > (CW+3)'(MaxV)) r = MaxV;
    else if (s < (CW+3)'(MinV)) r = MinV;
    else r = s[CW-1:0];
    return r;
  endfunction

  // box registers
  crd_t bmin_q [NumAxes];
  crd_t bmax_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        bmin_q[i] <= '0;
        bmax_q[i] <= OneV;
      end
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BOX_MIN_X: bmin_q[AxX] <= cfg_data_i;
        REG_BOX_MIN_Y: bmin_q[AxY] <= cfg_data_i;
        REG_BOX_MIN_Z: bmin_q[AxZ] <= cfg_data_i;
        REG_BOX_MAX_X: bmax_q[AxX] <= cfg_data_i;
        REG_BOX_MAX_Y: bmax_q[AxY] <= cfg_data_i;
        REG_BOX_MAX_Z: bmax_q[AxZ] <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // whole pipeline advances together and stalls while the output register holds an untaken result
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: offsets from origin to every face plane and slab bound
  crd_t              in_o [NumAxes];
  crd_t              in_d [NumAxes];
  logic signed [W-1:0] n1_d  [NumFaces];
  logic signed [W-1:0] lo1_d [NumAxes];
  logic signed [W-1:0] hi1_d [NumAxes];

  logic                v1_q;
  crd_t                o1_q  [NumAxes];
  crd_t                d1_q  [NumAxes];
  logic signed [W-1:0] n1_q  [NumFaces];
  logic signed [W-1:0] lo1_q [NumAxes];
  logic signed [W-1:0] hi1_q [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      in_o[i]  = s_axis_tdata[i*CW +: CW];
      in_d[i]  = s_axis_tdata[(i+3)*CW +: CW];
      lo1_d[i] = W'(bmin_q[i]) - W'(in_o[i]);
      hi1_d[i] = W'(bmax_q[i]) - W'(in_o[i]);
    end
    for (int f = 0; f < NumFaces; f++) begin
      n1_d[f] = ((f % 2) != 0)
                ? (W'(bmax_q[face_axis(f/2)]) - W'(in_o[face_axis(f/2)]))
                : (W'(bmin_q[face_axis(f/2)]) - W'(in_o[face_axis(f/2)]));
    end
  end

  // stage 2: cross products for crossing point and inclusion test
  logic signed [PW-1:0] pp2_d [NumFaces][Kept];
  logic signed [PW-1:0] ll2_d [NumFaces][Kept];
  logic signed [PW-1:0] hh2_d [NumFaces][Kept];

  logic                 v2_q;
  crd_t                 o2_q  [NumAxes];
  crd_t                 d2_q  [NumAxes];
  logic signed [W-1:0]  n2_q  [NumFaces];
  logic signed [PW-1:0] pp2_q [NumFaces][Kept];
  logic signed [PW-1:0] ll2_q [NumFaces][Kept];
  logic signed [PW-1:0] hh2_q [NumFaces][Kept];

  always_comb begin
    for (int f = 0; f < NumFaces; f++) begin
      for (int j = 0; j < Kept; j++) begin
        pp2_d[f][j] = PW'(n1_q[f]) * PW'(d1_q[other_axis(f/2, j)]);
        ll2_d[f][j] = PW'(lo1_q[other_axis(f/2, j)]) * PW'(d1_q[face_axis(f/2)]);
        hh2_d[f][j] = PW'(hi1_q[other_axis(f/2, j)]) * PW'(d1_q[face_axis(f/2)]);
      end
    end
  end

  // stage 3: which faces are crossed inside the box
  logic [NumFaces-1:0]  cnt3_d;

  logic                 v3_q;
  crd_t                 o3_q  [NumAxes];
  crd_t                 d3_q  [NumAxes];
  logic signed [W-1:0]  n3_q  [NumFaces];
  logic signed [PW-1:0] pp3_q [NumFaces][Kept];
  logic [NumFaces-1:0]  cnt3_q;

  always_comb begin
    logic pos;
    logic ok;
    for (int f = 0; f < NumFaces; f++) begin
      // a negative direction on the face axis flips both compares
      pos = !d2_q[face_axis(f/2)][CW-1];
      ok  = (d2_q[face_axis(f/2)] != '0);
      for (int j = 0; j < Kept; j++) begin
        if (pos) ok = ok && (pp2_q[f][j] >= ll2_q[f][j]) && (pp2_q[f][j] <= hh2_q[f][j]);
        else     ok = ok && (pp2_q[f][j] <= ll2_q[f][j]) && (pp2_q[f][j] >= hh2_q[f][j]);
      end
      cnt3_d[f] = ok;
    end
  end

  // stage 4: keep the first two faces, fold signs into magnitudes
  logic [FaceIdxW-1:0] sel [Kept];
  logic                fnd [Kept];
  logic [MW-1:0]       pmag4_d [Kept][Kept];
  logic                neg4_d  [Kept][Kept];
  logic [CW-1:0]       dmag4_d [Kept];
  logic [CW-1:0]       tn4_d   [Kept];

  logic                v4_q;
  logic                found4_q;
  crd_t                o4_q    [NumAxes];
  logic [FaceIdxW-1:0] face4_q [Kept];
  logic [MW-1:0]       pmag4_q [Kept][Kept];
  logic                neg4_q  [Kept][Kept];
  logic [CW-1:0]       dmag4_q [Kept];
  logic [CW-1:0]       tn4_q   [Kept];

  always_comb begin
    logic signed [PW-1:0] pv;
    logic signed [PW-1:0] pa;
    logic signed [W-1:0]  nv;
    logic signed [W-1:0]  na;
    crd_t                 da;
    for (int k = 0; k < Kept; k++) begin
      sel[k] = '0;
      fnd[k] = 1'b0;
    end
    // priority pick in face order
    for (int f = 0; f < NumFaces; f++) begin
      if (cnt3_q[f]) begin
        if (!fnd[0]) begin
          fnd[0] = 1'b1;
          sel[0] = FaceIdxW'(f);
        end else if (!fnd[1]) begin
          fnd[1] = 1'b1;
          sel[1] = FaceIdxW'(f);
        end
      end
    end
    for (int k = 0; k < Kept; k++) begin
      da = '0;
      nv = '0;
      for (int f = 0; f < NumFaces; f++) begin
        if (sel[k] == FaceIdxW'(f)) begin
          da = d3_q[face_axis(f/2)];
          nv = n3_q[f];
        end
      end
      dmag4_d[k] = da[CW-1] ? (~da + 1'b1) : da;
      na         = nv[W-1] ? -nv : nv;
      tn4_d[k]   = na[CW-1:0];
      for (int j = 0; j < Kept; j++) begin
        pv = '0;
        for (int f = 0; f < NumFaces; f++) begin
          if (sel[k] == FaceIdxW'(f)) pv = pp3_q[f][j];
        end
        pa            = pv[PW-1] ? -pv : pv;
        pmag4_d[k][j] = pa[MW-1:0];
        neg4_d[k][j]  = pv[PW-1] ^ da[CW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o1_q  <= in_o;
      d1_q  <= in_d;
      n1_q  <= n1_d;
      lo1_q <= lo1_d;
      hi1_q <= hi1_d;

      o2_q  <= o1_q;
      d2_q  <= d1_q;
      n2_q  <= n1_q;
      pp2_q <= pp2_d;
      ll2_q <= ll2_d;
      hh2_q <= hh2_d;

      o3_q   <= o2_q;
      d3_q   <= d2_q;
      n3_q   <= n2_q;
      pp3_q  <= pp2_q;
      cnt3_q <= cnt3_d;

      o4_q     <= o3_q;
      found4_q <= fnd[0] && fnd[1];
      face4_q  <= sel;
      pmag4_q  <= pmag4_d;
      neg4_q   <= neg4_d;
      dmag4_q  <= dmag4_d;
      tn4_q    <= tn4_d;
    end
  end

  // quotient pipelines, one per kept face and in-plane axis
  logic signed [CW+1:0] qs  [Kept][Kept];
  logic                 qov [Kept][Kept];
  logic                 qng [Kept][Kept];

  for (genvar k = 0; k < Kept; k++) begin : g_pick
    for (genvar j = 0; j < Kept; j++) begin : g_axis
      rbe_div #(
        .CW(CW)
      ) u_div (
        .clk_i      (clk_i),
        .en_i       (en),
        .dividend_i (pmag4_q[k][j]),
        .divisor_i  (dmag4_q[k]),
        .neg_i      (neg4_q[k][j]),
        .quot_o     (qs[k][j]),
        .ovf_o      (qov[k][j]),
        .neg_o      (qng[k][j])
      );
    end
  end

  // line parameter compare, cross-multiplied
  logic [MW-1:0] t0_q;
  logic [MW-1:0] t1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q <= MW'(tn4_q[0]) * MW'(dmag4_q[1]);
      t1_q <= MW'(tn4_q[1]) * MW'(dmag4_q[0]);
    end
  end

  // sideband riding alongside the quotient pipelines
  typedef struct packed {
    logic                              found;
    logic                              nearer;
    logic [Kept-1:0][FaceIdxW-1:0]     face;
    logic [NumAxes-1:0][CW-1:0]        org;
  } sb_t;

  sb_t  sb_q  [Lat];
  sb_t  sb_d  [Lat];
  logic sbv_q [Lat];

  always_comb begin
    sb_d[0].found  = found4_q;
    sb_d[0].nearer = 1'b0;
    for (int k = 0; k < Kept; k++) sb_d[0].face[k] = face4_q[k];
    for (int i = 0; i < NumAxes; i++) sb_d[0].org[i] = o4_q[i];
    for (int s = 1; s < Lat; s++) sb_d[s] = sb_q[s-1];
    // swap only when the first point is strictly farther
    sb_d[1].nearer = (t0_q > t1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Lat; s++) sbv_q[s] <= 1'b0;
    end else if (en) begin
      sbv_q[0] <= v4_q;
      for (int s = 1; s < Lat; s++) sbv_q[s] <= sbv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) sb_q <= sb_d;
  end

  // final assembly: face coordinate is the bound, the others origin plus quotient
  crd_t              pt  [Kept][NumAxes];
  logic [OutW-1:0]   out_d;
  logic [OutW-1:0]   out_data_q;
  sb_t               sbl;

  always_comb begin
    int nr;
    sbl = sb_q[Lat-1];
    for (int k = 0; k < Kept; k++) begin
      for (int c = 0; c < NumAxes; c++) pt[k][c] = '0;
      for (int f = 0; f < NumFaces; f++) begin
        if (sbl.face[k] == FaceIdxW'(f)) begin
          for (int c = 0; c < NumAxes; c++) begin
            if (c == face_axis(f/2)) begin
              pt[k][c] = ((f % 2) != 0) ? bmax_q[c] : bmin_q[c];
            end else if (c == other_axis(f/2, 0)) begin
              pt[k][c] = sat_add(sbl.org[c], qs[k][0], qov[k][0], qng[k][0]);
            end else begin
              pt[k][c] = sat_add(sbl.org[c], qs[k][1], qov[k][1], qng[k][1]);
            end
          end
        end
      end
    end
    nr    = sbl.nearer ? 1 : 0;
    out_d = '0;
    if (sbl.found) begin
      out_d[0] = 1'b1;
      for (int i = 0; i < NumAxes; i++) begin
        out_d[1 + i*CW +: CW]     = pt[nr][i];
        out_d[1 + (3+i)*CW +: CW] = pt[1-nr][i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sbv_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // a miss carries all-zero coordinates
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OutW-1:1] == '0)
    else $error("miss result with nonzero coordinates");

  // kept faces always have a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && found4_q |-> dmag4_q[0] != '0 && dmag4_q[1] != '0)
    else $error("kept face with zero direction component");

  // picks are distinct and in face order
  a_pick_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && found4_q |-> face4_q[0] < face4_q[1])
    else $error("face picks out of order");
`endif

endmodule

/* verif/ray_box_entry_exit_points_top_tb.sv */
`timescale 1ns / 1ps

module ray_box_entry_exit_points_top_tb;

  import rbe_pkg::*;

  localparam int CW      = 32;
  localparam int IN_W    = ((6*CW+7)/8)*8;
  localparam int OUT_W   = ((1+6*CW+7)/8)*8;
  localparam longint ONE = 64'sd65536;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int LATENCY = CW + 6;
  localparam int DRAIN_CYCLES = LATENCY + 12;
  localparam int STUCK_LIMIT = 5000;
  localparam int RANDOM_RAYS = 1200;

  // crossing points expected for one ray
  typedef struct {
    logic              hit;
    logic [CW-1:0]     near_pt [3];
    logic [CW-1:0]     far_pt  [3];
  } crossing_t;

  // faces visited in pairs: z, x, y; the two axes spanning each face plane
  localparam int FaceAx [3]    = '{2, 0, 1};
  localparam int PlaneAx [3][2] = '{'{0, 1}, '{1, 2}, '{0, 2}};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [CW-1:0]       cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;

  // box bounds as the predictor sees them, indexed by axis
  longint box_lo [3];
  longint box_hi [3];

  crossing_t expected_q [$];
  int        err_cnt;
  bit        steady;      // both sides stop idling while set
  int        stuck_cnt;

  ray_box_entry_exit_points_top #(
    .COORD_BITS (CW),
    .FRAC_BITS  (16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // hit, near_x, near_y, near_z, far_x, far_y, far_z, zero fill
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // saturate to the coordinate range
  function automatic longint clip_coord(input longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // exact line / box crossing; inclusion is decided on the unrounded ratio
  function automatic crossing_t cross_box(input longint o [3], input longint d [3]);
    crossing_t         res;
    longint            pts [2][3];
    logic signed [127:0] tn [2];
    logic signed [127:0] td [2];
    logic signed [127:0] p [2];
    logic signed [127:0] lim_lo, lim_hi, m, q;
    longint            bound, n, dm;
    int                found, a, b, nearer;
    bit                in_box;
    found = 0;
    for (int f = 0; f < 6 && found < 2; f++) begin
      a = FaceAx[f/2];
      bound = f[0] ? box_hi[a] : box_lo[a];
      if (d[a] == 0) continue;
      n = bound - o[a];
      dm = (d[a] < 0) ? -d[a] : d[a];
      in_box = 1'b1;
      for (int j = 0; j < 2; j++) begin
        b = PlaneAx[f/2][j];
        // scaled by |d_a| so the comparison stays integer
        p[j] = n;
        p[j] = p[j] * d[b];
        if (d[a] < 0) p[j] = -p[j];
        lim_lo = box_lo[b] - o[b];
        lim_lo = lim_lo * dm;
        lim_hi = box_hi[b] - o[b];
        lim_hi = lim_hi * dm;
        if (p[j] < lim_lo || p[j] > lim_hi) in_box = 1'b0;
      end
      if (!in_box) continue;
      pts[found][a] = bound;
      for (int j = 0; j < 2; j++) begin
        b = PlaneAx[f/2][j];
        // round half away from zero, magnitude clamped at 2^62
        m = (p[j] < 0) ? -p[j] : p[j];
        q = (2 * m + dm) / (2 * dm);
        if (q > (128'sd1 <<< 62)) q = 128'sd1 <<< 62;
        if (p[j] < 0) q = -q;
        pts[found][b] = clip_coord(o[b] + longint'(q));
      end
      tn[found] = (n < 0) ? -n : n;
      td[found] = dm;
      found++;
    end
    res.hit = (found == 2);
    nearer = 0;
    if (res.hit && tn[0] * td[1] > tn[1] * td[0]) nearer = 1;
    for (int i = 0; i < 3; i++) begin
      res.near_pt[i] = res.hit ? pts[nearer][i][CW-1:0] : '0;
      res.far_pt[i]  = res.hit ? pts[1-nearer][i][CW-1:0] : '0;
    end
    return res;
  endfunction

  function automatic longint rand_full();
    return longint'($signed(32'($urandom)));
  endfunction

  function automatic longint rand_span(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // one ray transaction; expectation is taken at the accepting edge
  task automatic send_ray(input longint o [3], input longint d [3]);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d[2][CW-1:0], d[1][CW-1:0], d[0][CW-1:0],
                      o[2][CW-1:0], o[1][CW-1:0], o[0][CW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(cross_box(o, d));
  endtask

  // every result in, then room for a ray that may still be in the pipe
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all six bounds, one register per cycle
  task automatic load_box(input longint lo [3], input longint hi [3]);
    reg_idx_e idx [6];
    longint   val [6];
    idx = '{REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z,
            REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z};
    val = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i][CW-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_lo = lo;
    box_hi = hi;
  endtask

  // random ray, mostly aimed at a point of the box so the faces get crossed
  task automatic send_random_ray();
    longint o [3], d [3], tgt [3];
    int     kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      if (kind < 3) begin
        o[i] = rand_full();
        d[i] = rand_full();
      end else begin
        o[i] = rand_span(-8 * ONE, 8 * ONE);
        tgt[i] = (box_lo[i] <= box_hi[i] && box_hi[i] - box_lo[i] < 64'sd2000000000)
                 ? rand_span(box_lo[i], box_hi[i]) : rand_span(-ONE, ONE);
        // snap to a bound now and then to land on edges and corners
        if ($urandom_range(0, 5) == 0) tgt[i] = $urandom_range(0, 1) ? box_hi[i] : box_lo[i];
        d[i] = (kind < 14) ? tgt[i] - o[i] : rand_span(-2 * ONE, 2 * ONE);
        d[i] = clip_coord(d[i]);
      end
      if ($urandom_range(0, 7) == 0) d[i] = 0;
    end
    send_ray(o, d);
  endtask

  task automatic test_unit_box_rays();
    longint o [3], d [3];
    // axis-parallel rays through each face pair, the z pair from either side
    o = '{ONE/2, ONE/2, -ONE};   d = '{0, 0, ONE};       send_ray(o, d);
    o = '{ONE/2, ONE/2, 2*ONE};  d = '{0, 0, -ONE};      send_ray(o, d);
    o = '{-ONE, ONE/4, ONE/2};   d = '{ONE, 0, 0};       send_ray(o, d);
    o = '{ONE/4, -ONE, ONE/2};   d = '{0, 3*ONE, 0};     send_ray(o, d);
    // origin inside the box: one crossing behind it
    o = '{ONE/3, ONE/3, ONE/3};  d = '{ONE, ONE/2, -ONE/7}; send_ray(o, d);
    // zero direction and a clean miss
    o = '{ONE/2, ONE/2, ONE/2};  d = '{0, 0, 0};         send_ray(o, d);
    o = '{2*ONE, 2*ONE, 2*ONE};  d = '{ONE, 0, 0};       send_ray(o, d);
    // through the corners and along an edge
    o = '{-ONE, -ONE, -ONE};     d = '{ONE, ONE, ONE};   send_ray(o, d);
    o = '{ONE, ONE/2, -ONE};     d = '{0, 0, ONE};       send_ray(o, d);
    o = '{0, 0, -ONE};           d = '{0, 0, 5};         send_ray(o, d);
    // half-ulp crossings, positive and negative
    o = '{0, 0, -1};             d = '{1, 0, 2};         send_ray(o, d);
    o = '{ONE/2, 0, -1};         d = '{-1, 0, 2};        send_ray(o, d);
    o = '{ONE/2, ONE/2, -3};     d = '{1, -1, 2};        send_ray(o, d);
    // field extremes
    o = '{CMAX, CMAX, CMAX};     d = '{CMIN, CMIN, CMIN}; send_ray(o, d);
    o = '{CMIN, CMIN, CMIN};     d = '{CMAX, CMAX, CMAX}; send_ray(o, d);
    o = '{ONE/2, ONE/2, CMIN};   d = '{CMAX, CMIN, 1};   send_ray(o, d);
    o = '{ONE/2, ONE/2, 0};      d = '{1, -1, CMIN};     send_ray(o, d);
    o = '{-1, -1, -1};           d = '{-1, -1, -1};      send_ray(o, d);
    o = '{0, 0, 0};              d = '{1, 1, 1};         send_ray(o, d);
  endtask

  task automatic test_box_settings();
    longint lo [3], hi [3];
    int     n_rays;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin lo = '{CMIN, CMIN, CMIN}; hi = '{CMAX, CMAX, CMAX}; end
        1: begin lo = '{ONE, 0, -ONE};     hi = '{0, ONE, ONE};      end  // inverted in x
        2: begin lo = '{-ONE, -ONE, ONE};  hi = '{ONE, ONE, ONE};    end  // flat in z
        3: begin lo = '{CMAX, CMAX, CMAX}; hi = '{CMAX, CMAX, CMAX}; end
        4: begin lo = '{CMIN, CMIN, CMIN}; hi = '{CMIN, CMIN, CMIN}; end
        default: begin
          for (int i = 0; i < 3; i++) begin
            lo[i] = rand_span(-4 * ONE, 4 * ONE);
            hi[i] = lo[i] + rand_span(0, 4 * ONE);
          end
        end
      endcase
      load_box(lo, hi);
      n_rays = (s < 5) ? 40 : RANDOM_RAYS / 3;
      steady = (s == 6);
      for (int k = 0; k < n_rays; k++) begin
        send_random_ray();
        // let the pipe run dry once mid-stream
        if (k == n_rays / 2 && s == 5) begin
          s_axis_tvalid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk_i);
        end
      end
      steady = 1'b0;
      drain();
    end
  endtask

  // result side: random stalls, then compare against the oldest expectation
  initial begin
    crossing_t exp_r;
    int        gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[0] !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, m_axis_tdata[0]);
          err_cnt++;
        end
        for (int i = 0; i < 3; i++) begin
          if (m_axis_tdata[1+CW*i +: CW] !== exp_r.near_pt[i]) begin
            $error("near_%s: expected %h, got %h", i == 0 ? "x" : i == 1 ? "y" : "z",
                   exp_r.near_pt[i], m_axis_tdata[1+CW*i +: CW]);
            err_cnt++;
          end
          if (m_axis_tdata[1+CW*(i+3) +: CW] !== exp_r.far_pt[i]) begin
            $error("far_%s: expected %h, got %h", i == 0 ? "x" : i == 1 ? "y" : "z",
                   exp_r.far_pt[i], m_axis_tdata[1+CW*(i+3) +: CW]);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  initial begin
    longint lo [3], hi [3];
    err_cnt       = 0;
    steady        = 1'b0;
    stuck_cnt     = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_BOX_MIN_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    box_lo = '{0, 0, 0};
    box_hi = '{ONE, ONE, ONE};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unit_box_rays();
    drain();
    test_box_settings();
    // back to the unit box
    lo = '{0, 0, 0};
    hi = '{ONE, ONE, ONE};
    load_box(lo, hi);
    test_unit_box_rays();
    drain();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rbe_pkg.sv
src/rbe_div.sv
src/ray_box_entry_exit_points_top.sv
verif/ray_box_entry_exit_points_top_tb.sv
